### hdl/huffman_tree_decoder_assert.svh
// Assertion shorthands for the huffman tree decoder checks.
`ifndef HUFFMAN_TREE_DECODER_ASSERT_SVH
`define HUFFMAN_TREE_DECODER_ASSERT_SVH

// Same-cycle implication.
`define HTD_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("htd check failed");

// Next-cycle implication.
`define HTD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("htd check failed");

`endif

### hdl/htd_pkg.sv
package htd_pkg;

   // parameter defaults
   localparam int NODES_DEF        = 256;
   localparam int MAX_CODE_LEN_DEF = 32;
   localparam int SYMBOL_BITS_DEF  = 8;

   // fixed field widths
   localparam int CODE_W   = 32;
   localparam int LEN_W    = 6;
   localparam int SYM_W    = 8;
   localparam int BYTE_W   = 8;
   localparam int CNT_W    = 4;
   localparam int STATUS_W = 2;

   localparam int BYTE_BITS = 8;

   // command codes
   localparam logic CMD_ADD    = 1'b0;
   localparam logic CMD_DECODE = 1'b1;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_BAD_BITS = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;

   typedef struct packed {
      logic [SYM_W-1:0]    decoded_symbol;
      logic [STATUS_W-1:0] status;
      logic                last;
   } htd_result_type;

endpackage

### hdl/htd_ifs.sv
interface htd_req_if;
   logic                          valid;
   logic                          ready;
   logic                          command;
   logic [htd_pkg::CODE_W-1:0]    code_bits;
   logic [htd_pkg::LEN_W-1:0]     code_length;
   logic [htd_pkg::SYM_W-1:0]     symbol;
   logic [htd_pkg::BYTE_W-1:0]    data_byte;
   logic [htd_pkg::CNT_W-1:0]     bit_count;

   modport source (output valid, command, code_bits, code_length, symbol, data_byte,
                   bit_count, input ready);
   modport sink   (input valid, command, code_bits, code_length, symbol, data_byte,
                   bit_count, output ready);
endinterface

interface htd_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [htd_pkg::SYM_W-1:0]     decoded_symbol;
   logic [htd_pkg::STATUS_W-1:0]  status;
   logic                          last;

   modport source (output valid, decoded_symbol, status, last, input ready);
   modport sink   (input valid, decoded_symbol, status, last, output ready);
endinterface

### hdl/htd_node_ram.sv
module htd_node_ram #(
   parameter int DEPTH = htd_pkg::NODES_DEF,
   parameter int WIDTH = 34
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/huffman_tree_decoder.sv
// Flow: an add word walks its code bits (L, capped at MAX_CODE_LEN), allocating new nodes
//   as needed; a decode word walks its data bits (N, at most 8) and can stall on the output.
// Throughput: one word at a time; each code bit costs one node-table read and one
//   evaluate step on the node RAM (one write port, one read port).
// Reset: synchronous, active high. After reset, state S_INIT clears the root node;
//   the input is not ready during it. Decoder returns to root, sticky error clears.
module huffman_tree_decoder #(
   parameter int NODES        = htd_pkg::NODES_DEF,
   parameter int MAX_CODE_LEN = htd_pkg::MAX_CODE_LEN_DEF,
   parameter int SYMBOL_BITS  = htd_pkg::SYMBOL_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   htd_req_if.sink    req_chan,
   htd_rsp_if.source  rsp_chan
);

   localparam int NB  = $clog2(NODES);          // node index bits
   localparam int NFW = NB + 1;                  // free pointer, can reach NODES
   localparam int LW  = $clog2(MAX_CODE_LEN + 1);
   localparam int SW  = htd_pkg::SYM_W;
   localparam int CW  = htd_pkg::CNT_W;
   localparam int BW  = htd_pkg::BYTE_W;

   // node entry: child0 | child1 | sym0 | sym1 | sym_valid0 | sym_valid1
   localparam int C0_LO = 0;
   localparam int C1_LO = NB;
   localparam int S0_LO = 2 * NB;
   localparam int S1_LO = 2 * NB + SYMBOL_BITS;
   localparam int V0    = 2 * NB + 2 * SYMBOL_BITS;
   localparam int V1    = V0 + 1;
   localparam int EW    = V1 + 1;

   localparam logic [2:0] S_INIT  = 3'd0;   // clear root after reset
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_A_RD  = 3'd2;   // add: read node
   localparam logic [2:0] S_A_EX  = 3'd3;   // add: follow, allocate, write symbol or report full
   localparam logic [2:0] S_A_NEW = 3'd4;   // add: zero the freshly allocated node
   localparam logic [2:0] S_D_RD  = 3'd5;   // decode: read node
   localparam logic [2:0] S_D_EX  = 3'd6;   // decode: evaluate one bit
   localparam logic [2:0] S_D_FIN = 3'd7;   // flush held result with last set

   // control state
   logic [2:0]       state_ff, state_in;
   logic [NFW-1:0]   next_free_ff, next_free_in;
   logic [NB-1:0]    cur_ff, cur_in;          // decode position, survives across words
   logic             err_ff, err_in;          // sticky unrecognized-bits flag
   logic             pend_v_ff, pend_v_in;    // one result held back until we know last
   logic             out_v_ff, out_v_in;

   // payload / datapath
   logic [MAX_CODE_LEN-1:0]    code_sr_ff, code_sr_in;   // code bits, one per step
   logic [LW-1:0]              alen_ff, alen_in;
   logic [SYMBOL_BITS-1:0]     sym_ff, sym_in;
   logic [NB-1:0]              walk_ff, walk_in;         // add walk position
   logic [BW-1:0]              data_sr_ff, data_sr_in;   // data bits, lsb first
   logic [CW-1:0]              dcnt_ff, dcnt_in;
   logic [SW-1:0]              pend_sym_ff, pend_sym_in;
   logic [htd_pkg::STATUS_W-1:0] pend_st_ff, pend_st_in;
   htd_pkg::htd_result_type    out_ff, out_in;

   // node RAM
   logic            ram_we, ram_re;
   logic [NB-1:0]   ram_waddr, ram_raddr;
   logic [EW-1:0]   ram_wdata, ram_rdata;

   htd_node_ram #(
      .DEPTH (NODES),
      .WIDTH (EW)
   ) u_node_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // branch view of the node just read
   logic                   br;
   logic [NB-1:0]          child_b;
   logic [SYMBOL_BITS-1:0] sym_b;
   logic                   sv_b;
   logic [EW-1:0]          ent_sym, ent_child;
   logic                   out_free;
   logic                   accept;
   logic                   have_res, ends;
   logic [SW-1:0]          res_sym;
   logic [htd_pkg::STATUS_W-1:0] res_st;

   assign br      = (state_ff == S_A_EX) ? code_sr_ff[0] : data_sr_ff[0];
   assign child_b = br ? ram_rdata[C1_LO +: NB] : ram_rdata[C0_LO +: NB];
   assign sym_b   = br ? ram_rdata[S1_LO +: SYMBOL_BITS] : ram_rdata[S0_LO +: SYMBOL_BITS];
   assign sv_b    = br ? ram_rdata[V1] : ram_rdata[V0];

   always_comb begin
      ent_sym   = ram_rdata;
      ent_child = ram_rdata;
      if (br) begin
         ent_sym[S1_LO +: SYMBOL_BITS] = sym_ff;
         ent_sym[V1]                   = 1'b1;
         ent_child[C1_LO +: NB]        = next_free_ff[NB-1:0];
      end else begin
         ent_sym[S0_LO +: SYMBOL_BITS] = sym_ff;
         ent_sym[V0]                   = 1'b1;
         ent_child[C0_LO +: NB]        = next_free_ff[NB-1:0];
      end
   end

   // decode bit outcome: symbol wins over child, neither is an error
   always_comb begin
      have_res = 1'b0;
      res_sym  = '0;
      res_st   = htd_pkg::ST_OK;
      if (sv_b) begin
         have_res = 1'b1;
         res_sym  = SW'(sym_b);
      end else if (child_b == '0) begin
         have_res = 1'b1;
         res_st   = htd_pkg::ST_BAD_BITS;
      end
      ends = (dcnt_ff == CW'(1)) || (!sv_b && child_b == '0);
   end

   assign out_free       = !out_v_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == S_IDLE);
   assign accept         = req_chan.valid && (state_ff == S_IDLE);

   always_comb begin
      state_in     = state_ff;
      next_free_in = next_free_ff;
      cur_in       = cur_ff;
      err_in       = err_ff;
      pend_v_in    = pend_v_ff;
      pend_sym_in  = pend_sym_ff;
      pend_st_in   = pend_st_ff;
      code_sr_in   = code_sr_ff;
      alen_in      = alen_ff;
      sym_in       = sym_ff;
      walk_in      = walk_ff;
      data_sr_in   = data_sr_ff;
      dcnt_in      = dcnt_ff;
      ram_we       = 1'b0;
      ram_waddr    = walk_ff;
      ram_wdata    = '0;
      ram_re       = 1'b0;
      ram_raddr    = walk_ff;
      out_v_in     = out_v_ff && !rsp_chan.ready;
      out_in       = out_ff;

      unique case (state_ff)
         S_INIT: begin
            ram_we    = 1'b1;
            ram_waddr = '0;
            state_in  = S_IDLE;
         end
         S_IDLE: begin
            if (accept) begin
               if (req_chan.command == htd_pkg::CMD_ADD) begin
                  // zero-length code is a no-op
                  if (req_chan.code_length != '0) begin
                     code_sr_in = MAX_CODE_LEN'(req_chan.code_bits);
                     alen_in    = (int'(req_chan.code_length) > MAX_CODE_LEN) ?
                                  LW'(MAX_CODE_LEN) : LW'(req_chan.code_length);
                     sym_in     = SYMBOL_BITS'(req_chan.symbol);
                     walk_in    = '0;
                     state_in   = S_A_RD;
                  end
               end else if (err_ff) begin
                  // sticky error: one bad-bits result per decode word
                  pend_v_in   = 1'b1;
                  pend_sym_in = '0;
                  pend_st_in  = htd_pkg::ST_BAD_BITS;
                  state_in    = S_D_FIN;
               end else if (req_chan.bit_count != '0) begin
                  data_sr_in = req_chan.data_byte;
                  dcnt_in    = (req_chan.bit_count > CW'(htd_pkg::BYTE_BITS)) ?
                               CW'(htd_pkg::BYTE_BITS) : req_chan.bit_count;
                  state_in   = S_D_RD;
               end
            end
         end
         S_A_RD: begin
            ram_re    = 1'b1;
            ram_raddr = walk_ff;
            state_in  = S_A_EX;
         end
         S_A_EX: begin
            if (alen_ff == LW'(1)) begin
               // final bit: symbol goes on this branch
               ram_we    = 1'b1;
               ram_waddr = walk_ff;
               ram_wdata = ent_sym;
               state_in  = S_IDLE;
            end else if (child_b != '0) begin
               walk_in    = child_b;
               code_sr_in = code_sr_ff >> 1;
               alen_in    = alen_ff - LW'(1);
               state_in   = S_A_RD;
            end else if (next_free_ff == NFW'(NODES)) begin
               pend_v_in   = 1'b1;
               pend_sym_in = '0;
               pend_st_in  = htd_pkg::ST_FULL;
               state_in    = S_D_FIN;
            end else begin
               ram_we    = 1'b1;
               ram_waddr = walk_ff;
               ram_wdata = ent_child;
               state_in  = S_A_NEW;
            end
         end
         S_A_NEW: begin
            ram_we       = 1'b1;
            ram_waddr    = next_free_ff[NB-1:0];
            ram_wdata    = '0;
            walk_in      = next_free_ff[NB-1:0];
            next_free_in = next_free_ff + NFW'(1);
            code_sr_in   = code_sr_ff >> 1;
            alen_in      = alen_ff - LW'(1);
            state_in     = S_A_RD;
         end
         S_D_RD: begin
            ram_re    = 1'b1;
            ram_raddr = cur_ff;
            state_in  = S_D_EX;
         end
         S_D_EX: begin
            // a new result displaces the held one; wait if the output is busy
            if (!(have_res && pend_v_ff && !out_free)) begin
               if (have_res) begin
                  if (pend_v_ff) begin
                     out_v_in = 1'b1;
                     out_in   = '{decoded_symbol: pend_sym_ff, status: pend_st_ff,
                                  last: 1'b0};
                  end
                  pend_v_in   = 1'b1;
                  pend_sym_in = res_sym;
                  pend_st_in  = res_st;
               end
               if (sv_b) begin
                  cur_in = '0;
               end else if (child_b != '0) begin
                  cur_in = child_b;
               end else begin
                  err_in = 1'b1;   // position left where it failed
               end
               data_sr_in = data_sr_ff >> 1;
               dcnt_in    = dcnt_ff - CW'(1);
               state_in   = ends ? S_D_FIN : S_D_RD;
            end
         end
         S_D_FIN: begin
            if (!pend_v_ff) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               out_v_in  = 1'b1;
               out_in    = '{decoded_symbol: pend_sym_ff, status: pend_st_ff, last: 1'b1};
               pend_v_in = 1'b0;
               state_in  = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         next_free_ff <= NFW'(1);
         cur_ff       <= '0;
         err_ff       <= 1'b0;
         pend_v_ff    <= 1'b0;
         out_v_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         next_free_ff <= next_free_in;
         cur_ff       <= cur_in;
         err_ff       <= err_in;
         pend_v_ff    <= pend_v_in;
         out_v_ff     <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      code_sr_ff  <= code_sr_in;
      alen_ff     <= alen_in;
      sym_ff      <= sym_in;
      walk_ff     <= walk_in;
      data_sr_ff  <= data_sr_in;
      dcnt_ff     <= dcnt_in;
      pend_sym_ff <= pend_sym_in;
      pend_st_ff  <= pend_st_in;
      out_ff      <= out_in;
   end

   assign rsp_chan.valid          = out_v_ff;
   assign rsp_chan.decoded_symbol = out_ff.decoded_symbol;
   assign rsp_chan.status         = out_ff.status;
   assign rsp_chan.last           = out_ff.last;

endmodule

### hdl/htd_checker.sv
`include "huffman_tree_decoder_assert.svh"

module htd_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [htd_pkg::SYM_W-1:0]     rsp_decoded_symbol,
   input logic [htd_pkg::STATUS_W-1:0]  rsp_status,
   input logic                          rsp_last
);

   // stalled word holds
   `HTD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_decoded_symbol) && $stable(rsp_status) && $stable(rsp_last))

   // any error ends its input word
   `HTD_ASSERT_NOW(a_err_last, clock, reset, rsp_valid && rsp_status != htd_pkg::ST_OK, rsp_last)

   // errors carry no symbol
   `HTD_ASSERT_NOW(a_err_nosym, clock, reset, rsp_valid && rsp_status != htd_pkg::ST_OK, rsp_decoded_symbol == '0)

   // root clear cycle right after reset
   `HTD_ASSERT_NOW(a_init_busy, clock, reset, $fell(reset), !req_ready && !rsp_valid && (req_valid || !req_valid))

endmodule

bind huffman_tree_decoder htd_checker u_htd_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_chan.valid),
   .req_ready          (req_chan.ready),
   .rsp_valid          (rsp_chan.valid),
   .rsp_ready          (rsp_chan.ready),
   .rsp_decoded_symbol (rsp_chan.decoded_symbol),
   .rsp_status         (rsp_chan.status),
   .rsp_last           (rsp_chan.last)
);

### tb/sv/symbol_scoreboard_pkg.sv
`timescale 1ns / 100ps

package symbol_scoreboard_pkg;

   localparam int TREE_NODES   = htd_pkg::NODES_DEF;
   localparam int CODE_LEN_CAP = htd_pkg::MAX_CODE_LEN_DEF;

   // one request word, all fields as driven
   typedef struct {
      logic                         command;
      logic [htd_pkg::CODE_W-1:0]   code_bits;
      logic [htd_pkg::LEN_W-1:0]    code_length;
      logic [htd_pkg::SYM_W-1:0]    symbol;
      logic [htd_pkg::BYTE_W-1:0]   data_byte;
      logic [htd_pkg::CNT_W-1:0]    bit_count;
   } tree_word_type;

   function automatic htd_pkg::htd_result_type result_of(logic [htd_pkg::SYM_W-1:0] sym,
                                                         logic [htd_pkg::STATUS_W-1:0] st,
                                                         logic fin);
      htd_pkg::htd_result_type r;
      r.decoded_symbol = sym;
      r.status         = st;
      r.last           = fin;
      return r;
   endfunction

   class symbol_scoreboard;
      // shadow of the code tree; a zero child means none
      bit [8:0]                 kid    [TREE_NODES][2];
      bit [htd_pkg::SYM_W-1:0]  sym_id [TREE_NODES][2];
      bit                       sym_ok [TREE_NODES][2];
      int unsigned              free_node;
      int unsigned              cur_node;
      bit                       stuck;
      htd_pkg::htd_result_type  expected_symbols [$];
      int unsigned              errors;

      function new();
         free_node = 1;
         cur_node  = 0;
         stuck     = 1'b0;
         errors    = 0;
      endfunction

      function int unsigned pending();
         return expected_symbols.size();
      endfunction

      // Update the tree shadow for an accepted word and queue what it must produce.
      function void note_word(tree_word_type w);
         int unsigned             len;
         int unsigned             node;
         int unsigned             steps;
         int unsigned             n;
         bit                      b;
         htd_pkg::htd_result_type batch [htd_pkg::BYTE_BITS];
         if (w.command == htd_pkg::CMD_ADD) begin
            len = 32'(w.code_length);
            if (len == 0) return;
            if (len > CODE_LEN_CAP) len = CODE_LEN_CAP;
            node = 0;
            for (int i = 0; i + 1 < len; i++) begin
               b = w.code_bits[i];
               if (kid[node][b] == 0) begin
                  if (free_node >= TREE_NODES) begin
                     // nodes grabbed so far stay, no symbol written
                     expected_symbols.push_back(result_of('0, htd_pkg::ST_FULL, 1'b1));
                     return;
                  end
                  kid[free_node][0]    = '0;
                  kid[free_node][1]    = '0;
                  sym_ok[free_node][0] = 1'b0;
                  sym_ok[free_node][1] = 1'b0;
                  kid[node][b] = 9'(free_node);
                  free_node++;
               end
               node = 32'(kid[node][b]);
            end
            b = w.code_bits[len-1];
            sym_id[node][b] = w.symbol;
            sym_ok[node][b] = 1'b1;
         end else begin
            n = 0;
            if (stuck) begin
               batch[0] = result_of('0, htd_pkg::ST_BAD_BITS, 1'b0);
               n = 1;
            end else begin
               steps = (w.bit_count > htd_pkg::BYTE_BITS) ? htd_pkg::BYTE_BITS :
                       32'(w.bit_count);
               for (int i = 0; i < steps; i++) begin
                  b = w.data_byte[i];
                  if (sym_ok[cur_node][b]) begin
                     batch[n] = result_of(sym_id[cur_node][b], htd_pkg::ST_OK, 1'b0);
                     n++;
                     cur_node = 0;
                  end else if (kid[cur_node][b] != 0) begin
                     cur_node = 32'(kid[cur_node][b]);
                  end else begin
                     batch[n] = result_of('0, htd_pkg::ST_BAD_BITS, 1'b0);
                     n++;
                     stuck = 1'b1;
                     break;
                  end
               end
            end
            if (n > 0) batch[n-1].last = 1'b1;
            for (int i = 0; i < n; i++) expected_symbols.push_back(batch[i]);
         end
      endfunction

      function void check_result(htd_pkg::htd_result_type got);
         htd_pkg::htd_result_type want;
         if (expected_symbols.size() == 0) begin
            $error("result with nothing expected: decoded_symbol %0d status %0d last %0d",
                   got.decoded_symbol, got.status, got.last);
            errors++;
            return;
         end
         want = expected_symbols.pop_front();
         if (got.decoded_symbol !== want.decoded_symbol) begin
            $error("decoded_symbol: expected %0d, got %0d", want.decoded_symbol,
                   got.decoded_symbol);
            errors++;
         end
         if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            errors++;
         end
         if (got.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, got.last);
            errors++;
         end
      endfunction
   endclass

endpackage

### tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;

   localparam int RANDOM_WORDS = 400;
   localparam int BREAK_WORDS  = 50;
   localparam int GROW_BUDGET  = 200;   // node ceiling while the tree should stay usable
   localparam int HOLD_AT      = 60;    // result count that triggers the long sink stall
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 120;
   localparam int IDLE_LIMIT   = 4000;

   logic clock;
   logic reset;

   htd_req_if req_bus ();
   htd_rsp_if rsp_bus ();

   symbol_scoreboard_pkg::symbol_scoreboard sb = new();

   bit          quiet_send;
   int unsigned results_seen;
   int unsigned idle_cycles;

   huffman_tree_decoder u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // Mostly back to back, some short gaps, now and then a long one.
   function automatic int unsigned pick_gap(bit quiet);
      int unsigned r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic bit branch_live(int unsigned node, bit b);
      return sb.sym_ok[node][b] || sb.kid[node][b] != 0;
   endfunction

   // Unused fields get noise so every bit of every field toggles.
   function automatic symbol_scoreboard_pkg::tree_word_type add_word(
         logic [htd_pkg::CODE_W-1:0] bits, logic [htd_pkg::LEN_W-1:0] len,
         logic [htd_pkg::SYM_W-1:0] sym);
      symbol_scoreboard_pkg::tree_word_type w;
      w.command     = htd_pkg::CMD_ADD;
      w.code_bits   = bits;
      w.code_length = len;
      w.symbol      = sym;
      w.data_byte   = 8'($urandom);
      w.bit_count   = 4'($urandom);
      return w;
   endfunction

   function automatic symbol_scoreboard_pkg::tree_word_type decode_word(
         logic [htd_pkg::BYTE_W-1:0] data, logic [htd_pkg::CNT_W-1:0] cnt);
      symbol_scoreboard_pkg::tree_word_type w;
      w.command     = htd_pkg::CMD_DECODE;
      w.code_bits   = $urandom;
      w.code_length = 6'($urandom);
      w.symbol      = 8'($urandom);
      w.data_byte   = data;
      w.bit_count   = cnt;
      return w;
   endfunction

   // Random code word. It walks the live tree and only grows new nodes while the
   // table is under budget; past that it follows existing paths or stops short,
   // so late adds mostly overwrite symbols.
   function automatic symbol_scoreboard_pkg::tree_word_type make_add(int unsigned budget);
      symbol_scoreboard_pkg::tree_word_type w;
      int unsigned len;
      int unsigned walk;
      int unsigned node;
      int unsigned spent;
      int unsigned r;
      bit          b;
      bit          fresh;
      bit          grow;
      r = $urandom_range(0, 99);
      if (r < 70) len = $urandom_range(1, 6);
      else if (r < 95) len = $urandom_range(7, 12);
      else len = $urandom_range(13, 40);
      w = add_word($urandom, 6'(len), 8'($urandom));
      walk = (len > htd_pkg::MAX_CODE_LEN_DEF) ? htd_pkg::MAX_CODE_LEN_DEF : len;
      node  = 0;
      spent = 0;
      fresh = 1'b0;
      for (int i = 0; i + 1 < walk; i++) begin
         b = w.code_bits[i];
         grow = fresh || sb.kid[node][b] == 0;
         if (grow && sb.free_node + spent >= budget && !fresh && sb.kid[node][!b] != 0) begin
            b = !b;
            grow = 1'b0;
         end
         if (grow && sb.free_node + spent >= budget) begin
            w.code_length = 6'(i + 1);
            break;
         end
         w.code_bits[i] = b;
         if (grow) begin
            spent++;
            fresh = 1'b1;
         end else begin
            node = 32'(sb.kid[node][b]);
         end
      end
      return w;
   endfunction

   // Data byte built by walking the tree from where the decoder stands.
   // A clean walk takes a live branch wherever one exists, so the decoder trips only at
   // a dead end; a spoiled walk steers into an empty branch as soon as it finds one.
   function automatic symbol_scoreboard_pkg::tree_word_type make_decode(bit spoil);
      symbol_scoreboard_pkg::tree_word_type w;
      int unsigned node;
      int unsigned steps;
      int unsigned k;
      bit          b;
      w = decode_word(8'($urandom), 4'd0);
      k = $urandom_range(0, 19);
      if (k == 0) begin
         steps = 0;                                   // zero bit count, nothing consumed
      end else if (k == 1) begin
         steps = htd_pkg::BYTE_BITS;
         w.bit_count = 4'($urandom_range(9, 15));     // oversized count clamps to a byte
      end else begin
         steps = $urandom_range(1, htd_pkg::BYTE_BITS);
         w.bit_count = 4'(steps);
      end
      node = sb.cur_node;
      for (int i = 0; i < steps; i++) begin
         b = 1'($urandom_range(0, 1));
         if (spoil) begin
            if (branch_live(node, b) && !branch_live(node, !b)) b = !b;
         end else if (!branch_live(node, b)) begin
            b = !b;
         end
         w.data_byte[i] = b;
         if (sb.sym_ok[node][b]) node = 0;
         else node = 32'(sb.kid[node][b]);
      end
      return w;
   endfunction

   // Offer one word, wait for the handshake, then log it. Valid is only dropped
   // when a gap follows, so it never toggles twice in one step.
   task automatic push_word(input symbol_scoreboard_pkg::tree_word_type w);
      int unsigned gap;
      gap = pick_gap(quiet_send);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.command     <= w.command;
      req_bus.code_bits   <= w.code_bits;
      req_bus.code_length <= w.code_length;
      req_bus.symbol      <= w.symbol;
      req_bus.data_byte   <= w.data_byte;
      req_bus.bit_count   <= w.bit_count;
      do @(posedge clock); while (!req_bus.ready);
      sb.note_word(w);
   endtask

   // Stop offering and wait for the decoder to hand back everything owed.
   task automatic settle_out();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   // stimulus
   initial begin
      int unsigned r;
      req_bus.valid       <= 1'b0;
      req_bus.command     <= htd_pkg::CMD_ADD;
      req_bus.code_bits   <= '0;
      req_bus.code_length <= '0;
      req_bus.symbol      <= '0;
      req_bus.data_byte   <= '0;
      req_bus.bit_count   <= '0;
      reset               <= 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // --- directed ---
      push_word(add_word(32'hFFFF_FFFF, 6'd0, 8'd77));      // zero length, ignored
      push_word(decode_word(8'($urandom), 4'd0));           // zero bit count on empty tree
      push_word(add_word($urandom & ~32'h1, 6'd1, 8'h00));  // root branch 0 -> symbol 0
      // length 63 clamps to 32: all-ones chain of 31 nodes, symbol 255 at the tip
      push_word(add_word(32'hFFFF_FFFF, 6'd63, 8'hFF));
      push_word(add_word(32'h7FFF_FFFF, 6'd32, 8'hA5));     // same chain, ends on a 0
      push_word(add_word(($urandom & ~32'h3) | 32'h1, 6'd2, 8'h5A));
      push_word(decode_word(8'h00, 4'd8));                  // eight results from one byte
      push_word(decode_word(8'hFF, 4'd15));                 // clamped count, mid-code
      // add while the decoder is parked mid-code; root branch 0 gains a child
      push_word(add_word(($urandom & ~32'h3) | 32'h2, 6'd2, 8'h3C));
      push_word(decode_word(8'hFF, 4'd8));
      push_word(decode_word(8'hFF, 4'd8));
      push_word(decode_word(8'hFF, 4'd8));                  // reaches the tip, emits 255
      push_word(decode_word(8'hF1, 4'd5));                  // 5A, 0, 0, then one bit in
      push_word(add_word($urandom & ~32'h1, 6'd1, 8'h81));  // overwrite root branch 0
      push_word(decode_word(8'h00, 4'd1));                  // finishes 5A
      push_word(decode_word(8'hFC, 4'd2));                  // symbol wins over child: 81, 81
      push_word(decode_word(8'hFF, 4'd8));                  // 31 ones then a zero -> A5
      push_word(decode_word(8'hFF, 4'd8));
      push_word(decode_word(8'hFF, 4'd8));
      push_word(decode_word(8'h7F, 4'd8));

      settle_out();

      // --- random: clean walks over a growing tree, some noise ---
      for (int i = 0; i < RANDOM_WORDS; i++) begin
         quiet_send = (i >= 100 && i < 160);
         if (i == 200) settle_out();
         r = $urandom_range(0, 99);
         if (r < 55) push_word(make_decode(1'b0));
         else if (r < 92) push_word(make_add(GROW_BUDGET));
         else push_word(add_word($urandom, 6'd0, 8'($urandom)));
      end
      quiet_send = 1'b0;

      // --- table full: long fresh codes until the table runs out ---
      for (int k = 0; k < 40 && sb.free_node < symbol_scoreboard_pkg::TREE_NODES; k++)
      begin
         push_word(add_word($urandom, 6'($urandom_range(32, 63)), 8'($urandom)));
      end
      push_word(add_word($urandom, 6'd63, 8'($urandom)));

      // --- unrecognized bits: steer into an empty branch, decoder goes sticky ---
      for (int k = 0; k < 20 && !sb.stuck; k++) push_word(make_decode(1'b1));

      // --- broken tail: sticky decodes, full adds, overwrites that still land ---
      for (int i = 0; i < BREAK_WORDS; i++) begin
         r = $urandom_range(0, 99);
         if (r < 25) push_word(make_decode(1'b1));
         else if (r < 50) push_word(make_decode(1'b0));
         else if (r < 75) begin
            push_word(add_word($urandom, 6'($urandom_range(32, 63)), 8'($urandom)));
         end
         else push_word(make_add(symbol_scoreboard_pkg::TREE_NODES));
      end

      settle_out();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0) $display("testbench passed");
      else $display("testbench failed");
      $finish;
   end

   // Result sink: random backpressure, a quiet stretch, and one long hold
   // while the source keeps pushing so the decoder backs up into its input.
   initial begin : result_sink
      int unsigned             hold;
      htd_pkg::htd_result_type got;
      hold = 0;
      results_seen = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.decoded_symbol = rsp_bus.decoded_symbol;
            got.status         = rsp_bus.status;
            got.last           = rsp_bus.last;
            sb.check_result(got);
            results_seen++;
            if (results_seen == HOLD_AT) hold = HOLD_CYCLES;
         end
         if (hold > 0) begin
            rsp_bus.ready <= 1'b0;
            hold--;
         end else begin
            rsp_bus.ready <= 1'b1;
            hold = pick_gap(results_seen >= 150 && results_seen < 250);
         end
      end
   end

   // Hang detector: any handshake on either side resets the count.
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("testbench failed");
            $finish;
         end
      end
   end

endmodule
